// ===== hw/rtl/swal_pkg.sv =====
// Types and constants shared by the sliding-window admission limiter.
package swal_pkg;

    localparam logic [31:0] WINDOW_MS  = 32'd60000;
    localparam int          TIME_W     = 48;
    localparam int          STAMP_W    = 47;
    localparam int          ID_W       = 64;
    localparam int          CFG_IDX_W  = 2;
    localparam int          CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIVE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQ  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GRP  = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LIVE_LIM = 3'd1;
    localparam logic [2:0] ST_REQ_LIM  = 3'd2;
    localparam logic [2:0] ST_GRP_LIM  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic signed [TIME_W-1:0] now_time;
        logic [ID_W-1:0]          requester_id;
        logic [ID_W-1:0]          group_id;
    } t_request;

    typedef struct packed {
        logic       admitted;
        logic [2:0] status;
    } t_result;

    typedef struct packed {
        logic               valid;
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    requester;
        logic [ID_W-1:0]    group;
    } t_slot;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

endpackage

// ===== hw/rtl/sliding_window_admission_limiter.sv =====
// Sliding-window admission limiter: slot table in one memory, scanned per request.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------
//  request   | i_start / o_busy   | i_req   (now_time, requester_id, group_id)
//  result    | o_done (strobe)    | o_result (admitted, status)
//  config    | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// A request runs from accept to the o_done strobe as a slot scan that reads one
// memory entry per cycle through a two-stage pipeline. After reset a clearing
// pass over every entry empties the table; o_busy is high meanwhile. o_busy
// stays high through the strobe cycle. The result is shown for one cycle and the
// receiver cannot stall it.
module sliding_window_admission_limiter #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  swal_pkg::t_request                   i_req,
    output logic                                 o_done,
    output swal_pkg::t_result                    o_result,
    input  logic                                 i_cfg_we,
    input  logic [swal_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [swal_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CNTW > 16) ? CNTW : 16;
    localparam int TW   = swal_pkg::TIME_W;

    // configuration
    logic [31:0] r_lifetime;
    logic [15:0] r_max_live, r_max_req, r_max_grp;

    // request context
    logic [swal_pkg::STAMP_W-1:0] r_now;
    logic [swal_pkg::ID_W-1:0]    r_reqid, r_grpid;
    logic [31:0]                  r_ttl, r_keep;

    swal_pkg::t_state r_state, n_state;

    logic [CNTW-1:0] r_rd_cnt;

    // slot memory
    swal_pkg::t_slot r_mem [TABLE_DEPTH];
    swal_pkg::t_slot r_mem_q;
    logic            mem_re, mem_we;
    logic [IW-1:0]   mem_raddr, mem_waddr;
    swal_pkg::t_slot mem_wdata;

    // scan pipeline
    logic                 r_s1_vld;
    logic [IW-1:0]        r_s1_idx;
    logic                 r_s2_vld;
    logic [IW-1:0]        r_s2_idx;
    logic                 r_s2_used;
    logic signed [TW-1:0] r_s2_age;
    logic                 r_s2_req_eq, r_s2_grp_eq;

    logic signed [TW-1:0] age_a;
    logic                 prune, age_le_ttl, age_le_win;

    logic [CNTW-1:0] r_live_n, r_req_n, r_grp_n;
    logic            r_free_found;
    logic [IW-1:0]   r_free_idx;

    logic [2:0] status;
    logic       accept;
    logic       scan_done;

    assign accept    = i_start && !o_busy;
    assign mem_raddr = r_rd_cnt[IW-1:0];
    assign scan_done = (r_rd_cnt == CNTW'(TABLE_DEPTH)) && !r_s1_vld && !r_s2_vld;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= '0;
            r_max_live <= '0;
            r_max_req  <= '0;
            r_max_grp  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                swal_pkg::CFG_LIFETIME: r_lifetime <= i_cfg_data;
                swal_pkg::CFG_MAX_LIVE: r_max_live <= i_cfg_data[15:0];
                swal_pkg::CFG_MAX_REQ:  r_max_req  <= i_cfg_data[15:0];
                swal_pkg::CFG_MAX_GRP:  r_max_grp  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // request context latched at accept; negative time clamps to zero
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now   <= i_req.now_time[TW-1] ? '0 : i_req.now_time[swal_pkg::STAMP_W-1:0];
            r_reqid <= i_req.requester_id;
            r_grpid <= i_req.group_id;
            r_ttl   <= (r_lifetime != '0) ? r_lifetime : swal_pkg::WINDOW_MS;
            r_keep  <= (r_lifetime > swal_pkg::WINDOW_MS) ? r_lifetime
                                                           : swal_pkg::WINDOW_MS;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swal_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // stage B decisions on the registered slot
    assign prune      = r_s2_used && (r_s2_age > $signed({16'b0, r_keep}));
    assign age_le_ttl = r_s2_age <= $signed({16'b0, r_ttl});
    assign age_le_win = r_s2_age <= $signed({16'b0, swal_pkg::WINDOW_MS});

    always_comb begin
        if (r_max_live != '0 && CMPW'(r_live_n) >= CMPW'(r_max_live)) begin
            status = swal_pkg::ST_LIVE_LIM;
        end else if (r_max_req != '0 && CMPW'(r_req_n) >= CMPW'(r_max_req)) begin
            status = swal_pkg::ST_REQ_LIM;
        end else if (r_max_grp != '0 && CMPW'(r_grp_n) >= CMPW'(r_max_grp)) begin
            status = swal_pkg::ST_GRP_LIM;
        end else if (!r_free_found) begin
            status = swal_pkg::ST_FULL;
        end else begin
            status = swal_pkg::ST_OK;
        end
    end

    // next state and memory control
    always_comb begin
        n_state   = r_state;
        o_busy    = 1'b1;
        o_done    = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_s2_idx;
        mem_wdata = '0;
        o_result.admitted = (status == swal_pkg::ST_OK);
        o_result.status   = status;
        unique case (r_state)
            swal_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_rd_cnt[IW-1:0];
                if (r_rd_cnt == CNTW'(TABLE_DEPTH - 1)) begin
                    n_state = swal_pkg::S_IDLE;
                end
            end
            swal_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    n_state = swal_pkg::S_SCAN;
                end
            end
            swal_pkg::S_SCAN: begin
                mem_re = (r_rd_cnt != CNTW'(TABLE_DEPTH));
                // stale slot: write back as empty
                mem_we = r_s2_vld && prune;
                if (scan_done) begin
                    n_state = swal_pkg::S_DECIDE;
                end
            end
            swal_pkg::S_DECIDE: begin
                o_done    = 1'b1;
                mem_we    = (status == swal_pkg::ST_OK);
                mem_waddr = r_free_idx;
                mem_wdata = '{valid: 1'b1, stamp: r_now, requester: r_reqid,
                              group: r_grpid};
                n_state   = swal_pkg::S_IDLE;
            end
            default: n_state = swal_pkg::S_CLEAR;
        endcase
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

    // address counter, shared by clearing pass and scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt <= '0;
        end else if (accept) begin
            r_rd_cnt <= '0;
        end else if (r_state == swal_pkg::S_CLEAR || mem_re) begin
            r_rd_cnt <= r_rd_cnt + 1'b1;
        end
    end

    // stage A: age and id matches
    assign age_a = $signed({1'b0, r_now}) - $signed({1'b0, r_mem_q.stamp});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= mem_re;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx    <= mem_raddr;
        r_s2_idx    <= r_s1_idx;
        r_s2_used   <= r_mem_q.valid;
        r_s2_age    <= age_a;
        r_s2_req_eq <= (r_mem_q.requester == r_reqid);
        r_s2_grp_eq <= (r_mem_q.group == r_grpid);
    end

    // stage B: counts and first free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live_n     <= '0;
            r_req_n      <= '0;
            r_grp_n      <= '0;
            r_free_found <= 1'b0;
        end else if (accept) begin
            r_live_n     <= '0;
            r_req_n      <= '0;
            r_grp_n      <= '0;
            r_free_found <= 1'b0;
        end else if (r_s2_vld) begin
            if (!r_s2_used || prune) begin
                if (!r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end else begin
                if (age_le_ttl) begin
                    r_live_n <= r_live_n + 1'b1;
                end
                if (age_le_win && r_s2_req_eq) begin
                    r_req_n <= r_req_n + 1'b1;
                end
                if (age_le_win && r_s2_grp_eq) begin
                    r_grp_n <= r_grp_n + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld && (!r_s2_used || prune) && !r_free_found) begin
            r_free_idx <= r_s2_idx;
        end
    end

    // assertions
    a_admit_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.admitted == (o_result.status == swal_pkg::ST_OK)))
        else $error("admitted flag disagrees with status");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> (!r_s1_vld && !r_s2_vld))
        else $error("scan pipeline active while idle");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == swal_pkg::S_SCAN && r_rd_cnt == '0))
        else $error("accepted request did not start a scan");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("prune write hits the entry being read");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

endmodule

// ===== verif/admission_checker.sv =====
`timescale 1ns / 1ps
// Checker: predicts each admission verdict and compares it with the limiter's result strobe.
module admission_checker #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_busy,
    input  swal_pkg::t_request                   i_req,
    input  logic                                 i_done,
    input  swal_pkg::t_result                    i_result,
    input  logic                                 i_cfg_we,
    input  logic [swal_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [swal_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                   o_errors,
    output int                                   o_pending
);
    import swal_pkg::*;

    logic               slot_used  [TABLE_DEPTH];
    logic [STAMP_W-1:0] slot_stamp [TABLE_DEPTH];
    logic [ID_W-1:0]    slot_req   [TABLE_DEPTH];
    logic [ID_W-1:0]    slot_grp   [TABLE_DEPTH];

    logic [31:0] lifetime_ms;
    logic [15:0] cap_live;
    logic [15:0] cap_req;
    logic [15:0] cap_grp;

    t_result verdicts_due[$];
    int      mismatches = 0;
    int      results_seen = 0;

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t: result %0d: %s", $time, results_seen, what);
    endtask

    // negative times count as zero
    function automatic longint i_req_clamp(input logic signed [TIME_W-1:0] t);
        return t[TIME_W-1] ? 64'sd0 : longint'(t[STAMP_W-1:0]);
    endfunction

    // Prune, count and (on a pass) record one request; returns the verdict.
    function automatic t_result judge_request(input t_request r);
        longint      now_ms;
        longint      window;
        longint      ttl;
        longint      keep;
        longint      age;
        int unsigned n_live;
        int unsigned n_req;
        int unsigned n_grp;
        int          free_idx;
        int          i;
        t_result     v;
        window   = longint'(WINDOW_MS);
        now_ms   = i_req_clamp(r.now_time);
        ttl      = (lifetime_ms != 0) ? longint'(lifetime_ms) : window;
        keep     = (ttl > window) ? ttl : window;
        n_live   = 0;
        n_req    = 0;
        n_grp    = 0;
        free_idx = -1;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (!slot_used[i]) begin
                if (free_idx < 0) free_idx = i;
            end else begin
                // negative age (time went backwards) is never pruned and always counts as live and in the window
                age = now_ms - longint'(slot_stamp[i]);
                if (age > keep) begin
                    slot_used[i] = 1'b0;
                    if (free_idx < 0) free_idx = i;
                end else begin
                    if (age <= ttl) n_live++;
                    if (age <= window && slot_req[i] == r.requester_id) n_req++;
                    if (age <= window && slot_grp[i] == r.group_id) n_grp++;
                end
            end
        end
        if (cap_live != 0 && n_live >= cap_live)
            v.status = ST_LIVE_LIM;
        else if (cap_req != 0 && n_req >= cap_req)
            v.status = ST_REQ_LIM;
        else if (cap_grp != 0 && n_grp >= cap_grp)
            v.status = ST_GRP_LIM;
        else if (free_idx < 0)
            v.status = ST_FULL;
        else begin
            v.status             = ST_OK;
            slot_used[free_idx]  = 1'b1;
            slot_stamp[free_idx] = now_ms[STAMP_W-1:0];
            slot_req[free_idx]   = r.requester_id;
            slot_grp[free_idx]   = r.group_id;
        end
        v.admitted = (v.status == ST_OK);
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        int k;
        if (!i_rst_n) begin
            for (k = 0; k < TABLE_DEPTH; k++) slot_used[k] = 1'b0;
            lifetime_ms = '0;
            cap_live    = '0;
            cap_req     = '0;
            cap_grp     = '0;
            verdicts_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LIFETIME: lifetime_ms = i_cfg_data;
                    CFG_MAX_LIVE: cap_live    = i_cfg_data[15:0];
                    CFG_MAX_REQ:  cap_req     = i_cfg_data[15:0];
                    CFG_MAX_GRP:  cap_grp     = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_done) begin
                results_seen++;
                if (verdicts_due.size() == 0) begin
                    flag_mismatch("result strobe with no request outstanding");
                end else begin
                    want = verdicts_due.pop_front();
                    if (i_result.admitted !== want.admitted)
                        flag_mismatch($sformatf("admitted %b, expected %b",
                                                i_result.admitted, want.admitted));
                    if (i_result.status !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                i_result.status, want.status));
                end
            end
            if (i_start && !i_busy) verdicts_due = {verdicts_due, judge_request(i_req)};
        end
        o_pending <= verdicts_due.size();
        o_errors  <= mismatches;
    end

endmodule

// ===== verif/tb_sliding_window_admission_limiter.sv =====
`timescale 1ns / 1ps
// Testbench top: drives requests and limit settings into the admission limiter.
module tb_sliding_window_admission_limiter;
    import swal_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int STALL_LIMIT = 4000;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  start    = 1'b0;
    logic                  busy;
    t_request              req      = '0;
    logic                  done;
    t_result               result;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = CFG_LIFETIME;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int          err_count;
    int          pending;
    int          quiet_cycles = 0;
    longint      base_ms = 0;
    logic [63:0] req_pool [8];
    logic [63:0] grp_pool [8];

    sliding_window_admission_limiter #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_req      (req),
        .o_done     (done),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    admission_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_verdicts (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_req      (req),
        .i_done     (done),
        .i_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (err_count),
        .o_pending  (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // stall watchdog: any accepted request, result or register write restarts it
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly back-to-back or short, now and then long enough to outlast a scan
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 20);
        return $urandom_range(21, 300);
    endfunction

    task automatic push_request(input logic [47:0] t, input logic [63:0] rq,
                                input logic [63:0] gp);
        t_request r;
        int       gap;
        r.now_time     = t;
        r.requester_id = rq;
        r.group_id     = gp;
        req   <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off until every outstanding request has its result and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
    endtask

    task automatic set_limits(input logic [31:0] life, input logic [15:0] live,
                              input logic [15:0] per_req, input logic [15:0] per_grp);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LIFETIME;
        cfg_data <= life;
        @(posedge clk);
        cfg_idx  <= CFG_MAX_LIVE;
        cfg_data <= {16'd0, live};
        @(posedge clk);
        cfg_idx  <= CFG_MAX_REQ;
        cfg_data <= {16'd0, per_req};
        @(posedge clk);
        cfg_idx  <= CFG_MAX_GRP;
        cfg_data <= {16'd0, per_grp};
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Time walks forward in random steps from a fresh base far past every stored
    // entry; ids come from small pools so the per-requester and per-group counts bite.
    task automatic run_phase(input logic [31:0] life, input logic [15:0] live,
                             input logic [15:0] per_req, input logic [15:0] per_grp,
                             input int n_items, input int max_step,
                             input int n_req, input int n_grp);
        longint      t;
        logic [63:0] rq;
        logic [63:0] gp;
        logic [63:0] rnd;
        int          roll;
        int          k;
        set_limits(life, live, per_req, per_grp);
        base_ms += 64'd10_000_000_000 + $urandom_range(0, 100000);
        for (k = 0; k < 8; k++) begin
            req_pool[k] = rand64();
            grp_pool[k] = rand64();
        end
        if ($urandom_range(0, 3) == 0) req_pool[0] = '1;
        if ($urandom_range(0, 3) == 0) grp_pool[0] = '0;
        for (k = 0; k < n_items; k++) begin
            roll = $urandom_range(0, 99);
            rq   = req_pool[$urandom_range(0, n_req - 1)];
            gp   = grp_pool[$urandom_range(0, n_grp - 1)];
            if (roll < 6) begin
                rnd = rand64();
                t   = longint'({16'hFFFF, 1'b1, rnd[46:0]});
            end else if (roll < 12) begin
                base_ms += $urandom_range(0, max_step);
                t  = base_ms;
                rq = rand64();
                gp = rand64();
            end else if (roll < 17) begin
                t = base_ms - $urandom_range(0, max_step);
            end else begin
                base_ms += $urandom_range(0, max_step);
                t = base_ms;
            end
            push_request(t[47:0], rq, gp);
            if ($urandom_range(0, 49) == 0) drain();
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset limits: everything admitted; negative times clamp to zero
        push_request(48'h8000_0000_0000, 64'd0, 64'd0);
        push_request(48'hFFFF_FFFF_FFFF, 64'd0, 64'd0);
        push_request(48'd0, '1, '1);

        // requester and group limits, window edge, time going backwards
        set_limits(32'd0, 16'd0, 16'd2, 16'd3);
        push_request(48'd0, 64'd0, 64'd7);
        push_request(48'd5, 64'd1, 64'd0);
        push_request(48'd6, 64'd2, 64'd0);
        push_request(48'd60000, 64'd0, 64'd8);
        push_request(48'd60001, 64'd0, 64'd8);
        push_request(48'd3, 64'd0, 64'd8);
        push_request(48'd4, 64'd0, 64'd9);

        // lifetime shorter than the window, live limit
        set_limits(32'd100, 16'd2, 16'd0, 16'd0);
        push_request(48'd200, 64'd5, 64'd5);
        push_request(48'd250, 64'd6, 64'd6);
        push_request(48'd301, 64'd6, 64'd6);

        // lifetime longer than the window: old entries live on but leave the window
        set_limits(32'd120000, 16'd0, 16'd1, 16'd0);
        push_request(48'd130000, 64'd5, 64'd9);
        push_request(48'd130001, 64'd0, 64'd9);
        push_request(48'd130002, 64'd0, 64'd9);

        run_phase(32'd0, 16'd0, 16'd3, 16'd5, 150, 1500, 6, 3);
        // limits off, small steps: the table fills and refuses
        run_phase(32'd0, 16'd0, 16'd0, 16'd0, 290, 60, 8, 8);
        run_phase(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 60, 5000, 4, 4);
        run_phase(32'd1, 16'd1, 16'd0, 16'd0, 60, 2, 4, 4);
        run_phase(32'd250000, 16'd40, 16'd4, 16'd6, 120, 3000, 5, 3);
        run_phase(32'd30000, 16'd12, 16'd1, 16'd0, 60, 20000, 6, 4);
        // close to the top of the time range
        base_ms = 64'h7FFF_FFFF_FFFF - 64'd10_002_000_000;
        run_phase(32'd0, 16'd0, 16'd2, 16'd0, 20, 50000, 3, 3);
        push_request(48'h7FFF_FFFF_FFFF, '1, '1);

        drain();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/swal_pkg.sv
hw/rtl/sliding_window_admission_limiter.sv
verif/admission_checker.sv
verif/tb_sliding_window_admission_limiter.sv
